// ----- design/rmt_pkg.sv -----
// Shared types and constants for the running median tracker.
// No dependencies; used by rmt_cell and running_median_tracker.
package rmt_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 9;

  // Per-chain update applied by every cell of the chain in the same cycle
  typedef logic [1:0] rmt_op_t;
  localparam rmt_op_t OP_HOLD    = 2'd0;  // keep contents
  localparam rmt_op_t OP_INS     = 2'd1;  // sorted insert of the sample
  localparam rmt_op_t OP_INS_POP = 2'd2;  // sorted insert, then drop the head
  localparam rmt_op_t OP_PUSH    = 2'd3;  // shift away from head, new head enters

  typedef logic [DATA_W-1:0] rmt_data_t;

  // Broadcast to all cells of one chain
  typedef struct packed {
    rmt_op_t   op;
    rmt_data_t x;
  } rmt_ctl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    rmt_data_t val;
    logic      after;   // occupied and ordered after the sample
    logic      take_x;  // empty or ordered after the sample
  } rmt_link_t;

endpackage

// ----- design/running_median_tracker.sv -----
// Running median tracker: lower median of all samples since the last restart.
// Latency: result beat is valid the cycle after the input beat is accepted.
// Throughput: one sample per cycle while in_stall is low; every cell updates in parallel each beat.
// Reset: sample count and output valid clear; stored samples are not cleared
// and need no sweep, since only slots below the count are ever read.
// Depends on rmt_pkg and rmt_cell.
module running_median_tracker import rmt_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  in_sample,
  input  logic               in_start_new,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_median,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_overflow
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NL = (CAPACITY + 1) / 2;  // lower half, descending, head = median
  localparam int NU = CAPACITY / 2;        // upper half, ascending

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          overflow_r, overflow_nxt;

  logic          accept;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] nl, nu;
  logic          full;
  logic          go_low;

  rmt_ctl_t  l_ctl, u_ctl;
  rmt_link_t l_link [NL];
  rmt_link_t u_link [NU];
  rmt_link_t l_head, u_head, tail;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign n_eff  = in_start_new ? '0 : count_r;
  assign nl     = CW'(({1'b0, n_eff} + (CW+1)'(1)) >> 1);
  assign nu     = n_eff >> 1;
  assign full   = n_eff == CW'(CAPACITY);
  assign go_low = ~l_link[0].after;

  // Rebalance heads: lower gets min of sample and upper head, upper gets lower head
  assign l_head = '{val: (u_link[0].after ? in_sample : u_link[0].val),
                    after: 1'b0, take_x: 1'b0};
  assign u_head = '{val: l_link[0].val, after: 1'b0, take_x: 1'b0};
  assign tail   = '{val: '0, after: 1'b0, take_x: 1'b1};

  always_comb begin
    l_ctl.x  = in_sample;
    u_ctl.x  = in_sample;
    l_ctl.op = OP_HOLD;
    u_ctl.op = OP_HOLD;
    if (accept && !full) begin
      case ({n_eff[0], go_low})
        2'b01: begin
          l_ctl.op = OP_INS;
        end
        2'b00: begin
          l_ctl.op = OP_PUSH;
          u_ctl.op = OP_INS_POP;
        end
        2'b11: begin
          l_ctl.op = OP_INS_POP;
          u_ctl.op = OP_PUSH;
        end
        2'b10: begin
          u_ctl.op = OP_INS;
        end
        default: begin
          l_ctl.op = OP_HOLD;
          u_ctl.op = OP_HOLD;
        end
      endcase
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_low
    rmt_link_t prv, nxt;
    if (i == 0) begin : g_first
      assign prv = l_head;
    end else begin : g_mid
      assign prv = l_link[i-1];
    end
    if (i == NL - 1) begin : g_last
      assign nxt = tail;
    end else begin : g_inner
      assign nxt = l_link[i+1];
    end
    rmt_cell #(.CapW(CW), .Idx(i), .Descend(1'b1)) u_cell (
      .clk  (clk),
      .ctl  (l_ctl),
      .size (nl),
      .prev (prv),
      .next (nxt),
      .link (l_link[i])
    );
  end

  for (genvar i = 0; i < NU; i++) begin : g_up
    rmt_link_t prv, nxt;
    if (i == 0) begin : g_first
      assign prv = u_head;
    end else begin : g_mid
      assign prv = u_link[i-1];
    end
    if (i == NU - 1) begin : g_last
      assign nxt = tail;
    end else begin : g_inner
      assign nxt = u_link[i+1];
    end
    rmt_cell #(.CapW(CW), .Idx(i), .Descend(1'b0)) u_cell (
      .clk  (clk),
      .ctl  (u_ctl),
      .size (nu),
      .prev (prv),
      .next (nxt),
      .link (u_link[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    overflow_nxt  = overflow_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
      overflow_nxt  = full;
      count_nxt     = full ? n_eff : n_eff + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    overflow_r <= overflow_nxt;
  end

  // Median sits at the head of the lower chain; it holds while the beat is stalled
  assign out_valid    = out_valid_r;
  assign out_median   = l_link[0].val;
  assign out_count    = COUNT_W'(count_r);
  assign out_overflow = overflow_r;

endmodule

// ----- design/rmt_cell.sv -----
// One slot of a sorted chain: holds a value and updates from its neighbors.
// Depends on rmt_pkg.
module rmt_cell import rmt_pkg::*; #(
  parameter int CapW    = 9,
  parameter int Idx     = 0,
  parameter bit Descend = 1'b0
) (
  input  logic             clk,
  input  rmt_ctl_t         ctl,
  input  logic [CapW-1:0]  size,
  input  rmt_link_t        prev,
  input  rmt_link_t        next,
  output rmt_link_t        link
);

  rmt_data_t val_r;
  rmt_data_t val_nxt;
  logic      occ;
  logic      gt;

  assign occ = size > CapW'(Idx);
  assign gt  = Descend ? (val_r < ctl.x) : (val_r > ctl.x);

  assign link.val    = val_r;
  assign link.after  = occ & gt;
  assign link.take_x = ~occ | gt;

  always_comb begin
    case (ctl.op)
      OP_HOLD:    val_nxt = val_r;
      OP_INS:     val_nxt = prev.after ? prev.val : (link.take_x ? ctl.x : val_r);
      OP_INS_POP: val_nxt = link.after ? val_r : (next.take_x ? ctl.x : next.val);
      OP_PUSH:    val_nxt = prev.val;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- bench/rmt_median_checker.sv -----
// Checker for the running median tracker: watches both channels, predicts
// each result beat from the accepted input beats and compares field by field.
// Depends on rmt_pkg for the data and count widths.
module rmt_median_checker import rmt_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [DATA_W-1:0]  in_sample,
  input  logic               in_start_new,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [DATA_W-1:0]  out_median,
  input  logic [COUNT_W-1:0] out_count,
  input  logic               out_overflow,
  output int unsigned        outstanding,
  output int unsigned        mismatches
);

  typedef struct packed {
    logic [DATA_W-1:0]  median;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } median_beat_t;

  logic [DATA_W-1:0] sorted_vals [CAPACITY];
  int unsigned       held_n = 0;
  median_beat_t      pending_results [$];
  int unsigned       err_cnt = 0;

  // Sorted insert; ties land after equal values, which never changes the median.
  function automatic median_beat_t predict_insert(input logic [DATA_W-1:0] sample,
                                                  input logic start_new);
    median_beat_t res;
    int unsigned  pos;
    if (start_new)
      held_n = 0;
    res.overflow = (held_n >= CAPACITY);
    if (!res.overflow) begin
      pos = held_n;
      while (pos > 0 && sorted_vals[pos-1] > sample) begin
        sorted_vals[pos] = sorted_vals[pos-1];
        pos--;
      end
      sorted_vals[pos] = sample;
      held_n++;
    end
    res.median = sorted_vals[(held_n - 1) / 2];
    res.count  = held_n[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report(input string field, input logic [DATA_W-1:0] want,
                        input logic [DATA_W-1:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endtask

  always @(posedge clk) begin : watch
    median_beat_t want;
    median_beat_t predicted;
    if (!rst_n) begin
      held_n = 0;
      pending_results.delete();
    end else begin
      // push before pop so a same-edge result can never pair with a stale entry
      if (in_valid && !in_stall) begin
        predicted = predict_insert(in_sample, in_start_new);
        pending_results = {pending_results, predicted};
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result beat with nothing expected: median %0h count %0d",
                     out_median, out_count);
        end else begin
          want = pending_results.pop_front();
          if (out_median !== want.median)
            report("median", want.median, out_median);
          if (out_count !== want.count)
            report("count", want.count, out_count);
          if (out_overflow !== want.overflow)
            report("overflow", want.overflow, out_overflow);
        end
      end
    end
    outstanding <= pending_results.size();
    mismatches  <= err_cnt;
  end

endmodule

// ----- bench/tb_running_median_tracker.sv -----
// Testbench top for running_median_tracker: clock, reset, sample stimulus,
// receiver stall pattern, watchdog and verdict.
// Depends on rmt_pkg, running_median_tracker and rmt_median_checker.
module tb_running_median_tracker;
  import rmt_pkg::*;

  localparam int CAPACITY    = 256;
  localparam int ITEM_TARGET = 1300;
  localparam int HOLD_CYCLES = 300;
  localparam int WD_LIMIT    = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DATA_W-1:0]  in_sample = '0;
  logic               in_start_new = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DATA_W-1:0]  out_median;
  logic [COUNT_W-1:0] out_count;
  logic               out_overflow;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  running_median_tracker #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_start_new (in_start_new),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_median   (out_median),
    .out_count    (out_count),
    .out_overflow (out_overflow)
  );

  rmt_median_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_start_new (in_start_new),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_median   (out_median),
    .out_count    (out_count),
    .out_overflow (out_overflow),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bursts of random length; a zero gap keeps valid high across bursts.
  task automatic send_beat(input logic [DATA_W-1:0] sample, input logic start_new);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 3);
        default: gap = $urandom_range(4, 16);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    in_valid     <= 1'b1;
    in_sample    <= sample;
    in_start_new <= start_new;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // flavor 0: full range, 1: narrow range with many ties, 2: extremes and edges
  function automatic logic [DATA_W-1:0] pick_sample(input int unsigned flavor);
    logic [DATA_W-1:0] v;
    v = $urandom;
    case (flavor)
      1: v = $urandom_range(0, 7);
      2: case ($urandom_range(0, 5))
           0: v = '0;
           1: v = '1;
           2: v = {1'b1, {(DATA_W-1){1'b0}}};
           3: v = {1'b0, {(DATA_W-1){1'b1}}};
           4: v = '1 - $urandom_range(0, 3);
           default: v = $urandom_range(0, 3);
         endcase
      default: ;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int unsigned seq;
    int unsigned len;
    int unsigned flavor;
    int unsigned i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first beats after reset without a restart flag
    send_beat('0, 1'b0);
    send_beat('1, 1'b0);
    send_beat(32'd5, 1'b0);
    send_beat(32'd5, 1'b0);
    send_beat(32'd5, 1'b0);
    send_beat('0, 1'b0);
    send_beat('1, 1'b0);
    send_beat(32'h7fff_ffff, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    // restart, ties and out-of-order arrivals
    send_beat(32'd10, 1'b1);
    send_beat(32'd10, 1'b0);
    send_beat(32'd3, 1'b0);
    send_beat(32'd20, 1'b0);
    send_beat(32'd1, 1'b0);
    send_beat('1, 1'b1);
    send_beat('0, 1'b0);
    send_beat('0, 1'b1);
    send_beat('1, 1'b1);
    send_beat(32'd4, 1'b1);
    send_beat(32'd3, 1'b0);
    send_beat(32'd2, 1'b0);
    send_beat(32'd1, 1'b0);
    wait_drained();

    // Sequences each open with a restart. Sequences 0 and 4 are longer than the store,
    // so the sample drop and a restart from a full store can both get exercised.
    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      if (seq == 0 || seq == 4 || $urandom_range(0, 19) == 0)
        len = $urandom_range(CAPACITY + 1, CAPACITY + 20);
      else
        len = $urandom_range(1, 40);
      flavor = $urandom_range(0, 2);
      for (i = 0; i < len; i++)
        send_beat(pick_sample(flavor), (i == 0) || ($urandom_range(0, 49) == 0));
      if (seq == 6)
        wait_drained();
      seq++;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Receiver: stall density changes every stretch, with one long hold-off
  // while the sender keeps offering, to back the block up into its input.
  initial begin : receiver
    int unsigned mode_left;
    int unsigned stall_pct;
    bit          held_off;
    mode_left = 0;
    stall_pct = 0;
    held_off  = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && items_sent >= 400) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
